// ----- design/tplf_pkg.sv -----
// shared types, constants and the arctangent step table for the three-point line fit
// no dependencies; used by every module of the block
package tplf_pkg;

  localparam int CoordW = 24;
  localparam int AngleW = 16;
  localparam int ThrW   = 32;

  localparam logic [ThrW-1:0] ThrReset = 32'd6554;
  localparam int AngleMax = 23040;

  // floor(2^30 / 3) and the bias that keeps the dividend positive
  localparam logic [28:0] DivMul = 29'd357913941;
  localparam logic [26:0] DivOff = 27'd100663296;

  // 180 degrees with 16 fraction bits
  localparam int HalfTurn = 11796480;

  typedef struct packed {
    logic signed [CoordW-1:0] x_first;
    logic signed [CoordW-1:0] y_first;
    logic signed [CoordW-1:0] x_second;
    logic signed [CoordW-1:0] y_second;
    logic signed [CoordW-1:0] x_third;
    logic signed [CoordW-1:0] y_third;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] mean_x;
    logic signed [CoordW-1:0] mean_y;
    logic signed [AngleW-1:0] angle_deg;
    logic                     line_found;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic sum;
    logic dev;
    logic mul;
    logic acc;
    logic mean_mul;
    logic mean_fix;
    logic prep;
    logic flip;
    logic iter;
    logic round;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic k_last;
    logic iter_last;
  } status_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [21:0] atan_step(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/tplf_ctrl.sv -----
// sequencing state machine for the line fit: handshakes and datapath commands
// depends on tplf_pkg
module tplf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tplf_pkg::status_t status,
  output tplf_pkg::cmd_t    cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SUM   = 12'b000000000010,
    S_DEV   = 12'b000000000100,
    S_MUL   = 12'b000000001000,
    S_ACC   = 12'b000000010000,
    S_MMUL  = 12'b000000100000,
    S_MFIX  = 12'b000001000000,
    S_PREP  = 12'b000010000000,
    S_FLIP  = 12'b000100000000,
    S_ITER  = 12'b001000000000,
    S_ROUND = 12'b010000000000,
    S_WRITE = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_DEV;
      end
      S_DEV: begin
        cmd.dev    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.k_last ? S_MMUL : S_MUL;
      end
      S_MMUL: begin
        cmd.mean_mul = 1'b1;
        state_next   = S_MFIX;
      end
      S_MFIX: begin
        cmd.mean_fix = 1'b1;
        state_next   = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_FLIP;
      end
      S_FLIP: begin
        cmd.flip   = 1'b1;
        state_next = S_ITER;
      end
      S_ITER: begin
        cmd.iter   = 1'b1;
        state_next = status.iter_last ? S_ROUND : S_ITER;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (slot_free) begin
          cmd.write  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.write) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/tplf_dp.sv -----
// datapath of the line fit: sums, mean divide, threshold test, cordic, result register
// depends on tplf_pkg; driven by tplf_ctrl commands
module tplf_dp #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  tplf_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  tplf_pkg::cmd_t      cmd,
  output tplf_pkg::status_t   status,
  output tplf_pkg::out_item_t out_item
);

  localparam int SH  = 2 * COORD_FRAC_BITS - 16;
  localparam int SHP = (SH >= 0) ? SH : 0;
  localparam int SHN = (SH < 0) ? -SH : 0;
  localparam int ITW = $clog2(CORDIC_STEPS);

  logic        [31:0] thr;
  logic signed [23:0] px [3];
  logic signed [23:0] py [3];
  logic signed [25:0] sx, sy;
  logic        [55:0] lim_lo, lim_hi;
  logic signed [26:0] dx [3];
  logic signed [26:0] dy [3];
  logic        [26:0] ux, uy;
  logic        [1:0]  k;
  logic signed [53:0] pxx, pyy, pxy;
  logic signed [55:0] sxx, syy, sxy;
  logic        [55:0] mpx, mpy;
  logic        [23:0] mean_x, mean_y;
  logic               deg, above, sxy_zero, cx_neg;
  logic signed [59:0] cx, cy;
  logic signed [27:0] z;
  logic [ITW-1:0]     it;
  logic signed [15:0] ang_fin, last_angle;

  logic        [35:0] t9;
  logic        [55:0] tsh;
  logic signed [26:0] dxs, dys;
  logic        [25:0] qx0, qy0;
  logic        [26:0] rx, ry;
  logic signed [59:0] xs, ys;
  logic signed [27:0] zstep, zr;
  logic signed [18:0] a19;
  logic signed [15:0] sat_ang;

  assign t9  = 36'(thr) * 36'd9;
  assign tsh = 56'(t9) << SHP;
  assign dxs = dx[k];
  assign dys = dy[k];
  assign qx0 = mpx[55:30];
  assign qy0 = mpy[55:30];
  assign rx  = ux - 27'(qx0) * 27'd3;
  assign ry  = uy - 27'(qy0) * 27'd3;
  assign xs  = cx >>> it;
  assign ys  = cy >>> it;
  assign zstep = 28'(tplf_pkg::atan_step(5'(it)));
  assign zr  = z + 28'sd256;
  assign a19 = 19'(zr >>> 9);

  always_comb begin
    if (a19 > 19'sd23040) begin
      sat_ang = 16'(tplf_pkg::AngleMax);
    end else if (a19 < -19'sd23040) begin
      sat_ang = -16'(tplf_pkg::AngleMax);
    end else begin
      sat_ang = 16'(a19);
    end
  end

  assign status.k_last    = (k == 2'd2);
  assign status.iter_last = (it == ITW'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      thr        <= tplf_pkg::ThrReset;
      last_angle <= '0;
    end else begin
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      if (cmd.write && !deg) begin
        last_angle <= ang_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px[0] <= in_item.x_first;
      py[0] <= in_item.y_first;
      px[1] <= in_item.x_second;
      py[1] <= in_item.y_second;
      px[2] <= in_item.x_third;
      py[2] <= in_item.y_third;
    end
    if (cmd.sum) begin
      sx     <= 26'(px[0]) + 26'(px[1]) + 26'(px[2]);
      sy     <= 26'(py[0]) + 26'(py[1]) + 26'(py[2]);
      lim_lo <= (tsh + ((56'd1 << SHN) - 56'd1)) >> SHN;
      lim_hi <= tsh >> SHN;
    end
    if (cmd.dev) begin
      for (int i = 0; i < 3; i++) begin
        dx[i] <= (27'(px[i]) <<< 1) + 27'(px[i]) - 27'(sx);
        dy[i] <= (27'(py[i]) <<< 1) + 27'(py[i]) - 27'(sy);
      end
      ux  <= 27'(sx) + 27'd1 + tplf_pkg::DivOff;
      uy  <= 27'(sy) + 27'd1 + tplf_pkg::DivOff;
      k   <= '0;
      sxx <= '0;
      syy <= '0;
      sxy <= '0;
    end
    if (cmd.mul) begin
      pxx <= 54'(dxs) * 54'(dxs);
      pyy <= 54'(dys) * 54'(dys);
      pxy <= 54'(dxs) * 54'(dys);
    end
    if (cmd.acc) begin
      sxx <= sxx + 56'(pxx);
      syy <= syy + 56'(pyy);
      sxy <= sxy + 56'(pxy);
      k   <= k + 2'd1;
    end
    if (cmd.mean_mul) begin
      mpx <= 56'(ux) * 56'(tplf_pkg::DivMul);
      mpy <= 56'(uy) * 56'(tplf_pkg::DivMul);
    end
    if (cmd.mean_fix) begin
      mean_x <= 24'(qx0 + 26'(rx >= 27'd3));
      mean_y <= 24'(qy0 + 26'(ry >= 27'd3));
    end
    if (cmd.prep) begin
      cx       <= 60'(syy) - 60'(sxx);
      cy       <= 60'(sxy) <<< 1;
      deg      <= ($unsigned(sxx) < lim_lo) && ($unsigned(syy) < lim_lo);
      above    <= $unsigned(syy) > lim_hi;
      sxy_zero <= (sxy == '0);
      cx_neg   <= (syy < sxx);
    end
    if (cmd.flip) begin
      it <= '0;
      if (cx[59]) begin
        z  <= (cy > 60'sd0) ? 28'(tplf_pkg::HalfTurn) : -28'(tplf_pkg::HalfTurn);
        cx <= -cx;
        cy <= -cy;
      end else begin
        z <= '0;
      end
    end
    if (cmd.iter) begin
      it <= it + 1'b1;
      if (!cy[59]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        z  <= z + zstep;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        z  <= z - zstep;
      end
    end
    if (cmd.round) begin
      if (deg) begin
        ang_fin <= last_angle;
      end else if (sxy_zero) begin
        if (cx_neg) begin
          ang_fin <= 16'(tplf_pkg::AngleMax);
        end else begin
          ang_fin <= above ? 16'sd0 : -16'(tplf_pkg::AngleMax);
        end
      end else begin
        ang_fin <= sat_ang;
      end
    end
    if (cmd.write) begin
      out_item.mean_x     <= mean_x;
      out_item.mean_y     <= mean_y;
      out_item.angle_deg  <= ang_fin;
      out_item.line_found <= !deg;
    end
  end

endmodule

// ----- design/three_point_line_fit_top.sv -----
// top level of the three-point total least squares line fit
// depends on tplf_pkg, tplf_ctrl and tplf_dp
//
// usage:
//   in_valid/in_ready carry one item of three points; out_valid/out_ready carry
//   one result item: mean point, angle to the vertical and the found flag
//   cfg_we/cfg_wdata write the degenerate threshold, to be done while idle
// timing:
//   one item is worked on at a time; the result is registered once the serial
//   cordic loop and the three multiply and accumulate passes over the points
//   are done, and a new item can be taken in the cycle after it is written
// reset (rst, synchronous):
//   threshold back to 6554, remembered angle to zero, no result pending
// stall:
//   a stalled result holds in the output register; the next item is still
//   worked on and waits in its last step until the register is free
module three_point_line_fit_top #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tplf_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tplf_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);

  tplf_pkg::cmd_t    cmd;
  tplf_pkg::status_t status;

  tplf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tplf_dp #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .CORDIC_STEPS    (CORDIC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule

// ----- design/tplf_chk.sv -----
// port-level checks for the line fit, bound to the top level
// depends on tplf_pkg and three_point_line_fit_top
module tplf_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tplf_pkg::out_item_t out_item
);

  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  a_one_at_a_time : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is in work");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_angle_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.angle_deg <= 16'sd23040) && (out_item.angle_deg >= -16'sd23040))
    else $error("angle out of range");

endmodule

bind three_point_line_fit_top tplf_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ----- tb/testbench.sv -----
// testbench for the three-point line fit: random and directed point triples,
// a local fixed-point predictor of mean and angle, checked against each result item
// depends on tplf_pkg and three_point_line_fit_top
`timescale 1ns / 1ps

module testbench;

  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tplf_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tplf_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  three_point_line_fit_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tplf_pkg::in_item_t pending_points[$];
  tplf_pkg::out_item_t expected_fits[$];
  logic [31:0] fit_threshold;
  logic signed [15:0] held_angle;
  int mismatches = 0;
  int fits_checked = 0;
  int degenerate_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int quiet_cycles = 0;
  bit pause_send = 1'b0;

  task automatic queue_points(tplf_pkg::in_item_t p);
    pending_points = {pending_points, p};
  endtask

  function automatic longint atan_entry(int i);
    longint tab[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1};
    return (i < 23) ? tab[i] : 64'sd0;
  endfunction

  function automatic longint mean_of_three(longint s);
    longint v, q;
    v = s + 1;
    q = v / 3;
    if (v % 3 < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [15:0] cordic_half_angle(longint x, longint y);
    longint z, xs, ys, a;
    z = 0;
    if (x < 0) begin
      z = (y > 0) ? (longint'(180) <<< 16) : -(longint'(180) <<< 16);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_entry(i);
      end else begin
        x = x - ys; y = y + xs; z = z - atan_entry(i);
      end
    end
    a = (z + 256) >>> 9;
    if (a > tplf_pkg::AngleMax) a = tplf_pkg::AngleMax;
    if (a < -tplf_pkg::AngleMax) a = -tplf_pkg::AngleMax;
    return a[15:0];
  endfunction

  function automatic tplf_pkg::out_item_t predict_fit(tplf_pkg::in_item_t p);
    longint px[3], py[3], sx, sy, sxx, syy, sxy, dx, dy, t9;
    tplf_pkg::out_item_t r;
    px[0] = p.x_first;  py[0] = p.y_first;
    px[1] = p.x_second; py[1] = p.y_second;
    px[2] = p.x_third;  py[2] = p.y_third;
    sx = px[0] + px[1] + px[2];
    sy = py[0] + py[1] + py[2];
    sxx = 0; syy = 0; sxy = 0;
    for (int k = 0; k < 3; k++) begin
      dx = 3 * px[k] - sx;
      dy = 3 * py[k] - sy;
      sxx += dx * dx;
      syy += dy * dy;
      sxy += dx * dy;
    end
    t9 = longint'(fit_threshold) * 9;
    r.mean_x = 24'(mean_of_three(sx));
    r.mean_y = 24'(mean_of_three(sy));
    if (sxx < t9 && syy < t9) begin
      r.line_found = 1'b0;
      r.angle_deg = held_angle;
    end else begin
      r.line_found = 1'b1;
      if (sxy == 0) begin
        if (syy >= sxx) r.angle_deg = (syy > t9) ? 16'sd0 : -16'sd23040;
        else r.angle_deg = 16'sd23040;
      end else begin
        r.angle_deg = cordic_half_angle(syy - sxx, 2 * sxy);
      end
      held_angle = r.angle_deg;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("error: %s got %0d expected %0d (result %0d)", what, got, want, fits_checked);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_fits = {expected_fits, predict_fit(in_item)};
        void'(pending_points.pop_front());
      end
      if ((in_valid && !in_ready) ) begin
        // hold
      end else if (!pause_send && pending_points.size() > (in_valid && in_ready ? 0 : 0)
                   && pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_item <= pending_points[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_fits.size() == 0) begin
          report_mismatch("result item with nothing expected", fits_checked, 0);
        end else begin
          tplf_pkg::out_item_t e;
          e = expected_fits.pop_front();
          if (out_item.mean_x !== e.mean_x) report_mismatch("mean_x", out_item.mean_x, e.mean_x);
          if (out_item.mean_y !== e.mean_y) report_mismatch("mean_y", out_item.mean_y, e.mean_y);
          if (out_item.angle_deg !== e.angle_deg)
            report_mismatch("angle_deg", out_item.angle_deg, e.angle_deg);
          if (out_item.line_found !== e.line_found)
            report_mismatch("line_found", out_item.line_found, e.line_found);
          if (!e.line_found) degenerate_seen++;
          fits_checked++;
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("three_point_line_fit_top: mismatch");
      $finish;
    end
  end

  function automatic logic signed [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return $signed(24'($urandom_range(4095))) - 24'sd2048;
      2: return ($urandom_range(1)) ? 24'(24'sh7fffff - 24'($urandom_range(3)))
                                    : 24'(24'sh800000 + 24'($urandom_range(3)));
      default: return $signed(24'($urandom_range(63))) - 24'sd32;
    endcase
  endfunction

  function automatic tplf_pkg::in_item_t random_points();
    tplf_pkg::in_item_t p;
    int mode;
    int kind;
    mode = $urandom_range(9);
    mode = (mode < 3) ? 0 : (mode < 6) ? 1 : (mode < 7) ? 2 : 3;
    p.x_first = rand_coord(mode);  p.y_first = rand_coord(mode);
    p.x_second = rand_coord(mode); p.y_second = rand_coord(mode);
    p.x_third = rand_coord(mode);  p.y_third = rand_coord(mode);
    kind = $urandom_range(9);
    if (kind == 0) begin
      p.x_second = p.x_first; p.x_third = p.x_first;
    end else if (kind == 1) begin
      p.y_second = p.y_first; p.y_third = p.y_first;
    end else if (kind == 2) begin
      p.x_second = p.x_first + 24'sd1; p.y_second = p.y_first;
      p.x_third = p.x_first; p.y_third = p.y_first;
    end
    return p;
  endfunction

  function automatic tplf_pkg::in_item_t pts(int a, int b, int c, int d, int e, int f);
    tplf_pkg::in_item_t p;
    p.x_first = 24'(a); p.y_first = 24'(b); p.x_second = 24'(c);
    p.y_second = 24'(d); p.x_third = 24'(e); p.y_third = 24'(f);
    return p;
  endfunction

  task automatic drain();
    wait (pending_points.size() == 0 && !in_valid);
    wait (expected_fits.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_threshold(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    fit_threshold = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) queue_points(random_points());
    drain();
  endtask

  initial begin
    fit_threshold = tplf_pkg::ThrReset;
    held_angle = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: degenerate first, extremes, axis-aligned and diagonal lines
    queue_points(pts(0, 0, 0, 0, 0, 0));
    queue_points(pts(0, 0, 0, 256, 0, 512));
    queue_points(pts(0, 0, 256, 0, 512, 0));
    queue_points(pts(0, 0, 1, 1, 0, 0));
    queue_points(pts(0, 0, 256, 256, 512, 512));
    queue_points(pts(0, 0, 256, -256, 512, -512));
    queue_points(pts(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    queue_points(pts(-8388608, -8388608, -8388608, -8388608,
                     -8388608, -8388608));
    queue_points(pts(-8388608, 8388607, 8388607, -8388608, 0, 0));
    queue_points(pts(8388607, 8388607, -8388608, -8388608, 0, 0));
    queue_points(pts(-8388608, 0, 8388607, 0, 0, 5));
    queue_points(pts(0, -8388608, 0, 8388607, 7, 0));
    queue_points(pts(1, 2, 3, 1, 2, 3));
    queue_points(pts(100, 0, -100, 0, 0, 300));
    queue_points(pts(-1, -1, -1, -1, -1, 2));
    queue_points(pts(0, 0, 30, 0, 0, 0));
    drain();

    // small threshold: sxy zero with syy equal and not above it
    set_threshold(32'd0);
    queue_points(pts(0, 0, 1, 0, 0, 1));
    queue_points(pts(0, 0, 0, 0, 0, 0));
    queue_points(pts(5, 5, 5, 6, 5, 7));
    drain();

    send_idle_pct = 9; recv_idle_pct = 60;
    random_phase(400);

    // long receiver hold-off while the sender keeps offering
    set_threshold(32'hffffffff);
    for (int i = 0; i < 20; i++) queue_points(random_points());
    send_idle_pct = 0;
    hold_off = 400;
    drain();

    set_threshold(32'd6554);
    send_idle_pct = 60; recv_idle_pct = 9;
    random_phase(400);

    set_threshold($urandom_range(65536));
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(400);

    set_threshold($urandom);
    random_phase(200);

    // sender pauses midway until every outstanding result has come back
    set_threshold(32'd1000000);
    for (int i = 0; i < 200; i++) queue_points(random_points());
    wait (pending_points.size() <= 100);
    pause_send = 1'b1;
    wait (!in_valid && expected_fits.size() == 0);
    repeat (20) @(posedge clk);
    pause_send = 1'b0;
    drain();

    $display("covered %0d fits over several thresholds, %0d degenerate triples",
             fits_checked, degenerate_seen);
    if (mismatches == 0 && expected_fits.size() == 0) begin
      $display("three_point_line_fit_top: match");
    end else begin
      $display("three_point_line_fit_top: mismatch");
    end
    $finish;
  end

endmodule
